/* rtl/pscc_pkg.sv */
// ----------------------------------------------------------------------------
// pscc_pkg: shared types and constants for the polygon store.
// Request and response structs, command codes and controller commands.
// ----------------------------------------------------------------------------
`default_nettype none
package pscc_pkg;

   localparam int MaxVertices = 64;
   localparam int CoordWidth  = 16;

   typedef enum logic [1:0] {
      CMD_CLEAR  = 2'd0,
      CMD_APPEND = 2'd1,
      CMD_QUERY  = 2'd2,
      CMD_CHECK  = 2'd3
   } cmd_type;

   typedef struct packed {
      logic [1:0]                 command;
      logic signed [CoordWidth-1:0] coord_x;
      logic signed [CoordWidth-1:0] coord_y;
   } req_type;

   typedef struct packed {
      logic       inside_res;
      logic       polygon_valid;
      logic [6:0] vertex_total;
      logic       store_full_error;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic latch_req;   // capture request fields
      logic do_clear;
      logic do_append;
      logic start_query; // reset edge walk for a query
      logic start_check; // reset pair walk for a check
      logic step;        // evaluate one edge or pair and advance
      logic finish;      // write result register
   } ctl_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic walk_done;   // last edge or pair evaluated
      logic few_verts;   // fewer than three vertices
   } sts_type;

endpackage
`default_nettype wire

/* rtl/pscc_datapath.sv */
// ----------------------------------------------------------------------------
// pscc_datapath: vertex memory, edge walk counters and the geometry tests.
// Each step fetches four vertices, one per phase, and evaluates one test.
// ----------------------------------------------------------------------------
`default_nettype none
module pscc_datapath #(
   parameter int MAX_VERTICES = pscc_pkg::MaxVertices,
   parameter int COORD_WIDTH  = pscc_pkg::CoordWidth
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire pscc_pkg::req_type req_data,
   input  wire pscc_pkg::ctl_type ctl,
   input  wire logic [1:0]        phase,
   output pscc_pkg::sts_type      sts,
   output pscc_pkg::rsp_type      rsp_data
);
   localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
   localparam int CW = $clog2(MAX_VERTICES + 1);
   localparam int DW = COORD_WIDTH + 1;        // difference width
   localparam int PW = 2 * DW + 1;             // product sum width

   typedef logic signed [COORD_WIDTH-1:0] crd_type;

   crd_type mem_x [MAX_VERTICES];
   crd_type mem_y [MAX_VERTICES];

   logic [CW-1:0] count_ff, count_in;
   logic          valid_ff, valid_in;
   logic          hits_ff, hits_in;
   logic          cross_ff, cross_in;
   logic [AW-1:0] i_ff, i_in, j_ff, j_in;
   crd_type       px_ff, py_ff;
   logic [1:0]    cmd_ff;
   logic          refused_ff;
   pscc_pkg::rsp_type rsp_ff, rsp_in;

   // Vertex registers fetched one per phase.
   crd_type ax_ff, ay_ff, bx_ff, by_ff, cx_ff, cy_ff, dx_ff, dy_ff;
   logic [AW-1:0] rd_addr;
   crd_type rd_x_ff, rd_y_ff;

   logic [AW-1:0] last_idx, i_prev, i_next, j_prev;
   assign last_idx = AW'(count_ff - CW'(1));
   assign i_prev = (i_ff == '0) ? last_idx : i_ff - AW'(1);
   assign i_next = (i_ff == last_idx) ? '0 : i_ff + AW'(1);
   assign j_prev = (j_ff == '0) ? last_idx : j_ff - AW'(1);

   logic is_check;
   assign is_check = (cmd_ff == pscc_pkg::CMD_CHECK);

   // Read address sequence: phase 0 a, 1 b, 2 c, 3 d (query uses i, i+1).
   always_comb begin
      case (phase)
         2'd0:    rd_addr = is_check ? i_prev : i_ff;
         2'd1:    rd_addr = is_check ? i_ff : i_next;
         2'd2:    rd_addr = j_prev;
         default: rd_addr = j_ff;
      endcase
   end

   // Memory write on append and registered read.
   always_ff @(posedge clock) begin
      if (ctl.do_append && count_ff < CW'(MAX_VERTICES)) begin
         mem_x[AW'(count_ff)] <= crd_type'(req_data.coord_x);
         mem_y[AW'(count_ff)] <= crd_type'(req_data.coord_y);
      end
      rd_x_ff <= mem_x[rd_addr];
      rd_y_ff <= mem_y[rd_addr];
   end

   // Read data is registered, so it is steered by the delayed phase.
   logic [1:0] phase_d_ff;
   always_ff @(posedge clock) begin
      phase_d_ff <= phase;
      case (phase_d_ff)
         2'd0:    begin ax_ff <= rd_x_ff; ay_ff <= rd_y_ff; end
         2'd1:    begin bx_ff <= rd_x_ff; by_ff <= rd_y_ff; end
         2'd2:    begin cx_ff <= rd_x_ff; cy_ff <= rd_y_ff; end
         default: begin dx_ff <= rd_x_ff; dy_ff <= rd_y_ff; end
      endcase
      if (ctl.latch_req) begin
         px_ff  <= crd_type'(req_data.coord_x);
         py_ff  <= crd_type'(req_data.coord_y);
         cmd_ff <= req_data.command;
         // An append is refused when the store is already full.
         refused_ff <= ctl.do_append && (count_ff == CW'(MAX_VERTICES));
      end
   end

   // Segment crossing and ray test terms, registered after the multiplies.
   logic signed [DW-1:0] v1x, v1y, v2x, v2y, v3x, v3y, qx, qy, ex, ey;
   assign v1x = DW'(ax_ff) - DW'(cx_ff);
   assign v1y = DW'(ay_ff) - DW'(cy_ff);
   assign v2x = DW'(dx_ff) - DW'(cx_ff);
   assign v2y = DW'(dy_ff) - DW'(cy_ff);
   assign v3x = DW'(ay_ff) - DW'(by_ff);
   assign v3y = DW'(bx_ff) - DW'(ax_ff);
   assign qx  = DW'(px_ff) - DW'(ax_ff);
   assign qy  = DW'(py_ff) - DW'(ay_ff);
   assign ex  = DW'(bx_ff) - DW'(ax_ff);
   assign ey  = DW'(by_ff) - DW'(ay_ff);

   logic signed [PW-1:0] m0_ff, m1_ff, m2_ff, m3_ff, m4_ff, m5_ff;
   logic signed [DW-1:0] qy_ff, ey_ff;
   always_ff @(posedge clock) begin
      if (is_check) begin
         m0_ff <= PW'(v2x * v3x); m1_ff <= PW'(v2y * v3y);
         m2_ff <= PW'(v2x * v1y); m3_ff <= PW'(v2y * v1x);
         m4_ff <= PW'(v1x * v3x); m5_ff <= PW'(v1y * v3y);
      end else begin
         m2_ff <= PW'(ex * qy);   m3_ff <= PW'(ey * qx);
         m0_ff <= '0; m1_ff <= '0; m4_ff <= '0; m5_ff <= '0;
      end
      qy_ff <= qy;
      ey_ff <= ey;
   end

   logic signed [PW-1:0] den, n1, n2;
   assign den = m0_ff + m1_ff;
   assign n1  = m2_ff - m3_ff;
   assign n2  = m4_ff + m5_ff;

   function automatic logic open_unit(logic signed [PW-1:0] num,
                                      logic signed [PW-1:0] dd);
      if (dd > 0) return (num > 0) && (num < dd);
      return (num < 0) && (num > dd);
   endfunction

   logic cross_now, hit_now;
   assign cross_now = (den != 0) && open_unit(n1, den) && open_unit(n2, den);
   assign hit_now = (ey_ff > 0) ? (n1 >= 0 && qy_ff >= 0 && qy_ff <= ey_ff) :
                    (ey_ff < 0) ? (n1 <= 0 && qy_ff <= 0 && qy_ff >= ey_ff) : 1'b0;

   // Walk counters and accumulators.
   always_comb begin
      count_in = count_ff;
      valid_in = valid_ff;
      hits_in  = hits_ff;
      cross_in = cross_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      rsp_in   = rsp_ff;
      if (ctl.do_clear) begin
         count_in = '0;
         valid_in = 1'b0;
      end
      if (ctl.do_append && count_ff < CW'(MAX_VERTICES)) count_in = count_ff + CW'(1);
      if (ctl.start_query || ctl.start_check) begin
         i_in = '0; j_in = '0; hits_in = 1'b0; cross_in = 1'b0;
      end
      if (ctl.step) begin
         if (is_check) begin
            cross_in = cross_ff | cross_now;
            if (j_ff == last_idx) begin
               j_in = '0;
               i_in = i_next;
            end else begin
               j_in = j_ff + AW'(1);
            end
         end else begin
            hits_in = hits_ff ^ hit_now;
            i_in = i_next;
         end
      end
      if (ctl.finish) begin
         if (cmd_ff == pscc_pkg::CMD_CHECK) valid_in = !sts.few_verts && !cross_ff;
         rsp_in.inside_res = (cmd_ff == pscc_pkg::CMD_QUERY) && !sts.few_verts && hits_ff;
         rsp_in.polygon_valid = valid_in;
         rsp_in.vertex_total = 7'(count_in);
         rsp_in.store_full_error = (cmd_ff == pscc_pkg::CMD_APPEND) && refused_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         valid_ff <= valid_in;
      end
      hits_ff  <= hits_in;
      cross_ff <= cross_in;
      i_ff     <= i_in;
      j_ff     <= j_in;
      rsp_ff   <= rsp_in;
   end

   assign sts.few_verts = (count_ff < CW'(3));
   assign sts.walk_done = is_check ? (i_ff == last_idx && j_ff == last_idx)
                                   : (i_ff == last_idx);
   assign rsp_data = rsp_ff;
endmodule
`default_nettype wire

/* rtl/pscc_control.sv */
// ----------------------------------------------------------------------------
// pscc_control: sequencer for the polygon store.
// Steps fetch four phases, drain the read and multiplier registers, then one evaluation.
// ----------------------------------------------------------------------------
`default_nettype none
module pscc_control (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire pscc_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   input  wire pscc_pkg::sts_type sts,
   output pscc_pkg::ctl_type      ctl,
   output logic [1:0]             phase
);
   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_START = 5'b00010,
      ST_FETCH = 5'b00100,
      ST_EVAL  = 5'b01000,
      ST_DONE  = 5'b10000
   } state_type;

   state_type state_ff, state_in;
   logic [2:0] cyc_ff, cyc_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic walk_cmd;

   // A query or check walks edges; clear and append finish at once.
   assign walk_cmd = (req_data.command == pscc_pkg::CMD_QUERY) ||
                     (req_data.command == pscc_pkg::CMD_CHECK);
   assign req_ready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign phase = cyc_ff[1:0];

   always_comb begin
      state_in = state_ff;
      cyc_in = cyc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      ctl = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_ready) begin
               ctl.latch_req = 1'b1;
               ctl.do_clear  = (req_data.command == pscc_pkg::CMD_CLEAR);
               ctl.do_append = (req_data.command == pscc_pkg::CMD_APPEND);
               ctl.start_query = (req_data.command == pscc_pkg::CMD_QUERY);
               ctl.start_check = (req_data.command == pscc_pkg::CMD_CHECK);
               state_in = walk_cmd ? ST_START : ST_DONE;
            end
         end
         ST_START: begin
            cyc_in = '0;
            state_in = sts.few_verts ? ST_DONE : ST_FETCH;
         end
         ST_FETCH: begin
            // Phases 0..3 issue reads, 4..5 drain memory and multiplier.
            cyc_in = cyc_ff + 3'd1;
            if (cyc_ff == 3'd5) state_in = ST_EVAL;
         end
         ST_EVAL: begin
            ctl.step = 1'b1;
            cyc_in = '0;
            state_in = sts.walk_done ? ST_DONE : ST_FETCH;
         end
         ST_DONE: begin
            ctl.finish = 1'b1;
            rsp_valid_in = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         cyc_ff <= '0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         cyc_ff <= cyc_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
endmodule
`default_nettype wire

/* rtl/polygon_simplicity_and_containment.sv */
// A query or check with fewer than three vertices skips the edge walk.
// Requests are handled one at a time; each edge or edge pair fetches four vertices
// in turn through the single read port of the vertex memory.
// Reset: synchronous, active high; clears vertex count, valid flag and control.
// Vertex memory contents are not cleared; entries beyond the vertex count are never used.
// ----------------------------------------------------------------------------
// polygon_simplicity_and_containment: top level of the polygon store.
// Joins the sequencer and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none
module polygon_simplicity_and_containment #(
   parameter int MAX_VERTICES = pscc_pkg::MaxVertices,
   parameter int COORD_WIDTH  = pscc_pkg::CoordWidth
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire pscc_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output pscc_pkg::rsp_type      rsp_data
);
   pscc_pkg::ctl_type ctl;
   pscc_pkg::sts_type sts;
   logic [1:0] phase;

   pscc_control u_control (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .rsp_valid, .rsp_ready, .sts, .ctl, .phase
   );

   pscc_datapath #(.MAX_VERTICES(MAX_VERTICES), .COORD_WIDTH(COORD_WIDTH)) u_datapath (
      .clock, .reset, .req_data, .ctl, .phase, .sts, .rsp_data
   );
endmodule
`default_nettype wire

/* rtl/pscc_checker.sv */
// ----------------------------------------------------------------------------
// pscc_checker: port-level assertions for the polygon store.
// Bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
module pscc_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_ready,
   input wire pscc_pkg::req_type req_data,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire pscc_pkg::rsp_type rsp_data
);
   // A held response keeps its payload.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_data))
      else $error("response changed while stalled");

   // No new request is taken while a response waits.
   a_noreq: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request accepted with response pending");

   // Inside is only reported for queries that see at least three vertices.
   a_inside: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.inside_res |-> rsp_data.vertex_total >= 7'd3)
      else $error("inside with too few vertices");

   // A clear reports an empty store.
   a_clear: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.command == pscc_pkg::CMD_CLEAR
      |=> ##1 rsp_valid && rsp_data.vertex_total == 7'd0 && !rsp_data.polygon_valid)
      else $error("clear response wrong");
endmodule

bind polygon_simplicity_and_containment pscc_checker u_pscc_checker (.*);
`default_nettype wire

/* bench/tb_polygon_simplicity_and_containment.sv */
// ----------------------------------------------------------------------------
// tb_polygon_simplicity_and_containment: self-checking bench for the polygon store.
// Drives clear, append, query and check requests, predicts every response
// with an in-bench model of the vertex store, and compares field by field.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_polygon_simplicity_and_containment;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WatchdogLimit = 200000;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   pscc_pkg::req_type req_data;
   logic              rsp_valid;
   logic              rsp_ready;
   pscc_pkg::rsp_type rsp_data;

   polygon_simplicity_and_containment dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   // Shadow copy of the polygon store.
   longint  shadow_x [pscc_pkg::MaxVertices];
   longint  shadow_y [pscc_pkg::MaxVertices];
   int      shadow_count;
   logic    shadow_valid;
   pscc_pkg::rsp_type pending_rsps [$];

   int error_count;
   int send_idle_pct;
   int recv_stall_pct;
   int hold_cycles;
   int request_count;
   int idle_cycles;

   // Clock generation.
   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // True when num/den lies strictly inside (0, 1).
   function automatic bit strictly_between(longint num, longint den);
      if (den > 0) return num > 0 && num < den;
      return num < 0 && num > den;
   endfunction

   // Strict interior crossing of edge a-b with edge c-d.
   function automatic bit edges_cross(int a, int b, int c, int d);
      longint v1x, v1y, v2x, v2y, v3x, v3y, den;
      v1x = shadow_x[a] - shadow_x[c];
      v1y = shadow_y[a] - shadow_y[c];
      v2x = shadow_x[d] - shadow_x[c];
      v2y = shadow_y[d] - shadow_y[c];
      v3x = -(shadow_y[b] - shadow_y[a]);
      v3y = shadow_x[b] - shadow_x[a];
      den = v2x * v3x + v2y * v3y;
      if (den == 0) return 1'b0;
      return strictly_between(v2x * v1y - v2y * v1x, den) &&
             strictly_between(v1x * v3x + v1y * v3y, den);
   endfunction

   // Ray toward +x from (px, py) against edge p-q, both ends inclusive.
   function automatic bit ray_hits_edge(longint px, longint py, int p, int q);
      longint v1x, v1y, v2x, v2y, cr;
      v1x = px - shadow_x[p];
      v1y = py - shadow_y[p];
      v2x = shadow_x[q] - shadow_x[p];
      v2y = shadow_y[q] - shadow_y[p];
      if (v2y == 0) return 1'b0;
      cr = v2x * v1y - v2y * v1x;
      if (v2y > 0) return cr >= 0 && v1y >= 0 && v1y <= v2y;
      return cr <= 0 && v1y <= 0 && v1y >= v2y;
   endfunction

   function automatic logic polygon_is_simple();
      int n;
      n = shadow_count;
      if (n < 3) return 1'b0;
      for (int i = 0; i < n; i++)
         for (int j = 0; j < n; j++)
            if (edges_cross((i == 0) ? n - 1 : i - 1, i, (j == 0) ? n - 1 : j - 1, j))
               return 1'b0;
      return 1'b1;
   endfunction

   function automatic logic point_inside(longint px, longint py);
      int hits;
      hits = 0;
      if (shadow_count < 3) return 1'b0;
      for (int i = 0; i < shadow_count; i++)
         if (ray_hits_edge(px, py, i, (i + 1 == shadow_count) ? 0 : i + 1)) hits++;
      return hits[0];
   endfunction

   // Update the shadow store for one accepted request and queue its response.
   task automatic predict_response(input pscc_pkg::req_type r);
      pscc_pkg::rsp_type e;
      e = '0;
      case (pscc_pkg::cmd_type'(r.command))
         pscc_pkg::CMD_CLEAR: begin
            shadow_count = 0;
            shadow_valid = 1'b0;
         end
         pscc_pkg::CMD_APPEND: begin
            if (shadow_count < pscc_pkg::MaxVertices) begin
               shadow_x[shadow_count] = longint'(r.coord_x);
               shadow_y[shadow_count] = longint'(r.coord_y);
               shadow_count++;
            end else begin
               e.store_full_error = 1'b1;
            end
         end
         pscc_pkg::CMD_QUERY:
            e.inside_res = point_inside(longint'(r.coord_x), longint'(r.coord_y));
         default: shadow_valid = polygon_is_simple();
      endcase
      e.polygon_valid = shadow_valid;
      e.vertex_total  = 7'(shadow_count);
      pending_rsps.push_back(e);
   endtask

   // Send one request; called and returns at a falling edge.
   task automatic send_req(input pscc_pkg::cmd_type c, input logic signed [15:0] x,
                           input logic signed [15:0] y);
      pscc_pkg::req_type r;
      r.command = c;
      r.coord_x = x;
      r.coord_y = y;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_response(r);
      request_count++;
      @(negedge clock);
   endtask

   // Receiver: random stalls, or a long counted hold-off when requested.
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         rsp_ready <= 1'b0;
         hold_cycles <= hold_cycles - 1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Response check and watchdog.
   always @(posedge clock) begin
      pscc_pkg::rsp_type e;
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WatchdogLimit) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsps.size() == 0) begin
            $error("response with no request outstanding: %p", rsp_data);
            error_count++;
         end else begin
            e = pending_rsps.pop_front();
            if (rsp_data.inside_res !== e.inside_res) begin
               $error("inside_res expected %0b actual %0b", e.inside_res,
                      rsp_data.inside_res);
               error_count++;
            end
            if (rsp_data.polygon_valid !== e.polygon_valid) begin
               $error("polygon_valid expected %0b actual %0b", e.polygon_valid,
                      rsp_data.polygon_valid);
               error_count++;
            end
            if (rsp_data.vertex_total !== e.vertex_total) begin
               $error("vertex_total expected %0d actual %0d", e.vertex_total,
                      rsp_data.vertex_total);
               error_count++;
            end
            if (rsp_data.store_full_error !== e.store_full_error) begin
               $error("store_full_error expected %0b actual %0b", e.store_full_error,
                      rsp_data.store_full_error);
               error_count++;
            end
         end
      end
   end

   // Coordinate with a mix of full range, small grid and extreme values.
   function automatic logic signed [15:0] pick_coord();
      case ($urandom_range(9))
         0, 1: return 16'($urandom);
         2: return ($urandom_range(1)) ? 16'sh7fff : 16'sh8000;
         default: return 16'(($urandom_range(16) - 8) * 256 + $urandom_range(3) * 64);
      endcase
   endfunction

   task automatic test_directed();
      send_req(pscc_pkg::CMD_QUERY, 16'sd0, 16'sd0);        // empty store
      send_req(pscc_pkg::CMD_CHECK, 16'sd0, 16'sd0);
      send_req(pscc_pkg::CMD_APPEND, 16'sd0, 16'sd0);
      send_req(pscc_pkg::CMD_APPEND, 16'sd1024, 16'sd0);
      send_req(pscc_pkg::CMD_CHECK, 16'sd0, 16'sd0);        // two vertices only
      send_req(pscc_pkg::CMD_QUERY, 16'sd256, 16'sd0);
      send_req(pscc_pkg::CMD_APPEND, 16'sd0, 16'sd1024);    // triangle
      send_req(pscc_pkg::CMD_CHECK, 16'sd0, 16'sd0);
      send_req(pscc_pkg::CMD_QUERY, 16'sd256, 16'sd256);    // inside
      send_req(pscc_pkg::CMD_QUERY, 16'sd0, 16'sd0);        // on a vertex, ray origin
      send_req(pscc_pkg::CMD_QUERY, 16'sd0, 16'sd1024);     // top vertex
      send_req(pscc_pkg::CMD_QUERY, -16'sd512, 16'sd0);     // along the horizontal edge
      send_req(pscc_pkg::CMD_QUERY, 16'sd2048, 16'sd256);   // outside
      send_req(pscc_pkg::CMD_APPEND, 16'sd1024, 16'sd1024); // bowtie
      send_req(pscc_pkg::CMD_CHECK, 16'sd0, 16'sd0);
      send_req(pscc_pkg::CMD_CLEAR, 16'sd0, 16'sd0);
      send_req(pscc_pkg::CMD_APPEND, 16'sh8000, 16'sh8000); // extreme square
      send_req(pscc_pkg::CMD_APPEND, 16'sh7fff, 16'sh8000);
      send_req(pscc_pkg::CMD_APPEND, 16'sh7fff, 16'sh7fff);
      send_req(pscc_pkg::CMD_APPEND, 16'sh8000, 16'sh7fff);
      send_req(pscc_pkg::CMD_CHECK, 16'sh7fff, 16'sh7fff);
      send_req(pscc_pkg::CMD_QUERY, 16'sh8000, 16'sh8000);
      send_req(pscc_pkg::CMD_QUERY, 16'sd0, 16'sd0);
      send_req(pscc_pkg::CMD_QUERY, 16'sh7fff, 16'sd0);
      send_req(pscc_pkg::CMD_CLEAR, 16'sh7fff, 16'sh8000);
   endtask

   // Fill the store, overflow it, then check and query the full polygon.
   task automatic test_store_full();
      int a;
      for (int i = 0; i < pscc_pkg::MaxVertices; i++) begin
         a = (i * 360) / pscc_pkg::MaxVertices;
         send_req(pscc_pkg::CMD_APPEND,
                  16'($rtoi(7000.0 * $cos(a * 3.14159265 / 180.0))),
                  16'($rtoi(7000.0 * $sin(a * 3.14159265 / 180.0))));
      end
      send_req(pscc_pkg::CMD_APPEND, 16'sd5, 16'sd5);
      send_req(pscc_pkg::CMD_APPEND, pick_coord(), pick_coord());
      send_req(pscc_pkg::CMD_CHECK, 16'sd0, 16'sd0);
      send_req(pscc_pkg::CMD_QUERY, 16'sd0, 16'sd0);
      send_req(pscc_pkg::CMD_QUERY, 16'sd7000, 16'sd0);
      send_req(pscc_pkg::CMD_QUERY, 16'sd9000, 16'sd10);
      send_req(pscc_pkg::CMD_CLEAR, 16'sd0, 16'sd0);
   endtask

   // Polygons of random size and content, mostly checked and each queried, with stray random requests.
   task automatic test_random_polygons(input int quota);
      int start, k, v;
      start = request_count;
      while (request_count - start < quota) begin
         if ($urandom_range(9) == 0) begin
            send_req(pscc_pkg::cmd_type'($urandom_range(3)), pick_coord(), pick_coord());
            continue;
         end
         send_req(pscc_pkg::CMD_CLEAR, pick_coord(), pick_coord());
         k = ($urandom_range(7) == 0) ? $urandom_range(2) : $urandom_range(3, 10);
         for (int i = 0; i < k; i++)
            send_req(pscc_pkg::CMD_APPEND, pick_coord(), pick_coord());
         if ($urandom_range(3) != 0)
            send_req(pscc_pkg::CMD_CHECK, pick_coord(), pick_coord());
         for (int q = $urandom_range(4, 12); q > 0; q--) begin
            if (k > 0 && $urandom_range(3) == 0) begin
               v = $urandom_range(k - 1);
               send_req(pscc_pkg::CMD_QUERY, 16'(shadow_x[v] - $urandom_range(1) * 256),
                        16'(shadow_y[v]));
            end else begin
               send_req(pscc_pkg::CMD_QUERY, pick_coord(), pick_coord());
            end
         end
      end
   endtask

   // Long receiver hold-off while requests keep coming.
   task automatic test_backpressure();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_cycles    = 400;
      for (int i = 0; i < 20; i++)
         send_req(pscc_pkg::CMD_QUERY, pick_coord(), pick_coord());
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_rsps.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   initial begin
      error_count    = 0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_cycles    = 0;
      request_count  = 0;
      idle_cycles    = 0;
      shadow_count   = 0;
      shadow_valid   = 1'b0;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_data       = '0;
      rsp_ready      = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_store_full();
      test_backpressure();
      send_idle_pct = 0;  recv_stall_pct = 0;  test_random_polygons(450);
      send_idle_pct = 57; recv_stall_pct = 0;  test_random_polygons(450);
      send_idle_pct = 0;  recv_stall_pct = 57; test_random_polygons(450);
      send_idle_pct = 18; recv_stall_pct = 18; test_random_polygons(450);
      wait_drained();

      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
`default_nettype wire

/* files.f */
rtl/pscc_pkg.sv
rtl/pscc_datapath.sv
rtl/pscc_control.sv
rtl/polygon_simplicity_and_containment.sv
rtl/pscc_checker.sv
bench/tb_polygon_simplicity_and_containment.sv
